// ===== sv/hmt_pkg.sv =====
package hmt_pkg;

  localparam int MAX_PEERS_DEF = 32;

  localparam int OP_W      = 2;
  localparam int ID_W      = 16;
  localparam int PORT_W    = 16;
  localparam int HB_W      = 32;
  localparam int TIME_W    = 32;
  localparam int TO_W      = 16;
  localparam int PER_W     = 8;
  localparam int EV_W      = 3;
  localparam int OUT_CNT_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_GOSSIP   = 2'd1;
  localparam logic [OP_W-1:0] OP_JOIN_REP = 2'd2;
  localparam logic [OP_W-1:0] OP_JOIN_REQ = 2'd3;

  // result events
  localparam logic [EV_W-1:0] EV_TICK    = 3'd0;
  localparam logic [EV_W-1:0] EV_ADDED   = 3'd1;
  localparam logic [EV_W-1:0] EV_UPDATED = 3'd2;
  localparam logic [EV_W-1:0] EV_IGNORED = 3'd3;
  localparam logic [EV_W-1:0] EV_FULL    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_TO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_PRT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_GROUP = 3'd5;

  // register reset values
  localparam logic [TO_W-1:0]   RST_FAIL_TO  = 16'd10;
  localparam logic [TO_W-1:0]   RST_CLEAN_TO = 16'd20;
  localparam logic [PER_W-1:0]  RST_PERIOD   = 8'd2;
  localparam logic [ID_W-1:0]   RST_SELF_ID  = 16'd1;
  localparam logic [PORT_W-1:0] RST_SELF_PRT = 16'd0;
  localparam logic              RST_IN_GROUP = 1'b1;

  // request broadcast to every cell while a scan runs
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [HB_W-1:0]   hb;
    logic              sender;
    logic              self_hit;
    logic              evict_en;
    logic [TIME_W-1:0] now;
    logic [TO_W-1:0]   fail_to;
    logic [TO_W-1:0]   clean_to;
  } hmt_req_t;

  // status flags handed from cell to cell along the chain
  typedef struct packed {
    logic valid;
    logic found;
    logic upd;
    logic free_hit;
  } hmt_link_t;

endpackage

// ===== sv/hmt_cell.sv =====
module hmt_cell #(
  parameter int MAX_PEERS = hmt_pkg::MAX_PEERS_DEF,
  parameter int IDX       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hmt_pkg::hmt_req_t             req,
  input  hmt_pkg::hmt_link_t            link_in,
  input  logic [$clog2(MAX_PEERS)-1:0]  free_idx_in,
  input  logic [$clog2(MAX_PEERS+1)-1:0] removed_in,
  input  logic                          add_en,
  input  logic [$clog2(MAX_PEERS)-1:0]  add_idx,
  output hmt_pkg::hmt_link_t            link_out,
  output logic [$clog2(MAX_PEERS)-1:0]  free_idx_out,
  output logic [$clog2(MAX_PEERS+1)-1:0] removed_out
);

  localparam int IdxW = $clog2(MAX_PEERS);
  localparam int CntW = $clog2(MAX_PEERS + 1);

  logic                       valid_r, valid_nxt;
  logic [hmt_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [hmt_pkg::PORT_W-1:0] port_r, port_nxt;
  logic [hmt_pkg::HB_W-1:0]   hb_r, hb_nxt;
  logic [hmt_pkg::TIME_W-1:0] stamp_r, stamp_nxt;
  hmt_pkg::hmt_link_t         link_r, link_nxt;
  logic [IdxW-1:0]            free_idx_r, free_idx_nxt;
  logic [CntW-1:0]            removed_r, removed_nxt;

  logic [hmt_pkg::TIME_W-1:0] age;
  logic                       is_tick, match, active, evict, upd, take_free, load;

  always_comb begin
    age       = req.now - stamp_r;
    is_tick   = (req.op == hmt_pkg::OP_TICK);
    match     = valid_r && (id_r == req.id) && (port_r == req.port);
    active    = (age <= hmt_pkg::TIME_W'(req.fail_to)) || req.sender;
    evict     = link_in.valid && is_tick && req.evict_en && valid_r &&
                (age > hmt_pkg::TIME_W'(req.clean_to));
    upd       = link_in.valid && (req.op == hmt_pkg::OP_GOSSIP) && !req.self_hit &&
                match && active && (req.hb > hb_r);
    take_free = !is_tick && !valid_r && !link_in.free_hit;
    load      = add_en && (add_idx == IdxW'(IDX));

    link_nxt          = link_in;
    link_nxt.found    = link_in.found | (!is_tick && match);
    link_nxt.upd      = link_in.upd | upd;
    link_nxt.free_hit = link_in.free_hit | take_free;
    free_idx_nxt      = take_free ? IdxW'(IDX) : free_idx_in;
    removed_nxt       = removed_in + CntW'(evict);

    valid_nxt = valid_r;
    id_nxt    = id_r;
    port_nxt  = port_r;
    hb_nxt    = hb_r;
    stamp_nxt = stamp_r;
    if (load) begin
      valid_nxt = 1'b1;
      id_nxt    = req.id;
      port_nxt  = req.port;
      hb_nxt    = req.hb;
      stamp_nxt = req.now;
    end else if (evict) begin
      valid_nxt = 1'b0;
    end else if (upd) begin
      hb_nxt    = req.hb;
      stamp_nxt = req.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      link_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      link_r  <= link_nxt;
    end
    id_r       <= id_nxt;
    port_r     <= port_nxt;
    hb_r       <= hb_nxt;
    stamp_r    <= stamp_nxt;
    free_idx_r <= free_idx_nxt;
    removed_r  <= removed_nxt;
  end

  assign link_out     = link_r;
  assign free_idx_out = free_idx_r;
  assign removed_out  = removed_r;

endmodule

// ===== sv/heartbeat_membership_table_core.sv =====
// Channel   Ports                                  Handshake
// input     in_opcode .. in_last_in_message        beat taken when start & !busy
// result    out_event_res .. out_in_group          one-cycle strobe out_valid
// config    cfg_we, cfg_index, cfg_wdata           write when cfg_we, no wait
//
// Every item walks the row of MAX_PEERS slot cells, one cell per cycle, and a
// new item is taken only once the current one has left the last cell and the
// block is idle again.
// Synchronous reset clears the table and loads register defaults at once.
// The receiver cannot stall: out_valid flags each result for one cycle only.
module heartbeat_membership_table_core #(
  parameter int MAX_PEERS = hmt_pkg::MAX_PEERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [hmt_pkg::OP_W-1:0]          in_opcode,
  input  logic [hmt_pkg::ID_W-1:0]          in_entry_id,
  input  logic [hmt_pkg::PORT_W-1:0]        in_entry_port,
  input  logic [hmt_pkg::HB_W-1:0]          in_entry_heartbeat,
  input  logic                              in_is_sender,
  input  logic                              in_last_in_message,
  output logic                              out_valid,
  output logic [hmt_pkg::EV_W-1:0]          out_event_res,
  output logic [hmt_pkg::OUT_CNT_W-1:0]     out_removed_count,
  output logic [hmt_pkg::OUT_CNT_W-1:0]     out_neighbour_count,
  output logic [hmt_pkg::HB_W-1:0]          out_self_heartbeat,
  output logic                              out_gossip_due,
  output logic                              out_in_group,
  input  logic                              cfg_we,
  input  logic [hmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hmt_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int IdxW = $clog2(MAX_PEERS);
  localparam int CntW = $clog2(MAX_PEERS + 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                       state_r, state_nxt;
  logic                         go_r, go_nxt;
  logic [hmt_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [hmt_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [hmt_pkg::PORT_W-1:0]   port_r, port_nxt;
  logic [hmt_pkg::HB_W-1:0]     hb_r, hb_nxt;
  logic                         sender_r, sender_nxt;
  logic                         self_hit_r, self_hit_nxt;
  logic                         evict_en_r, evict_en_nxt;
  logic                         due_r, due_nxt;

  logic [hmt_pkg::TO_W-1:0]     fail_to_r, fail_to_nxt;
  logic [hmt_pkg::TO_W-1:0]     clean_to_r, clean_to_nxt;
  logic [hmt_pkg::PER_W-1:0]    period_r, period_nxt;
  logic [hmt_pkg::ID_W-1:0]     self_id_r, self_id_nxt;
  logic [hmt_pkg::PORT_W-1:0]   self_port_r, self_port_nxt;

  logic [hmt_pkg::HB_W-1:0]     own_hb_r, own_hb_nxt;
  logic [hmt_pkg::PER_W-1:0]    countdown_r, countdown_nxt;
  logic                         member_r, member_nxt;
  logic [hmt_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [CntW-1:0]              count_r, count_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [hmt_pkg::EV_W-1:0]     ev_r, ev_nxt;
  logic [hmt_pkg::OUT_CNT_W-1:0] rem_out_r, rem_out_nxt;
  logic [hmt_pkg::OUT_CNT_W-1:0] cnt_out_r, cnt_out_nxt;

  hmt_pkg::hmt_req_t            req;
  hmt_pkg::hmt_link_t           link_w     [MAX_PEERS+1];
  logic [IdxW-1:0]              free_idx_w [MAX_PEERS+1];
  logic [CntW-1:0]              removed_w  [MAX_PEERS+1];
  logic                         add_en;
  logic                         accept, finish, is_tick;
  hmt_pkg::hmt_link_t           last;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    req.op       = op_r;
    req.id       = id_r;
    req.port     = port_r;
    req.hb       = hb_r;
    req.sender   = sender_r;
    req.self_hit = self_hit_r;
    req.evict_en = evict_en_r;
    req.now      = now_r;
    req.fail_to  = fail_to_r;
    req.clean_to = clean_to_r;

    link_w[0]       = '0;
    link_w[0].valid = go_r;
    free_idx_w[0]   = '0;
    removed_w[0]    = '0;
  end

  for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
    hmt_cell #(
      .MAX_PEERS (MAX_PEERS),
      .IDX       (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .req          (req),
      .link_in      (link_w[g]),
      .free_idx_in  (free_idx_w[g]),
      .removed_in   (removed_w[g]),
      .add_en       (add_en),
      .add_idx      (free_idx_w[MAX_PEERS]),
      .link_out     (link_w[g+1]),
      .free_idx_out (free_idx_w[g+1]),
      .removed_out  (removed_w[g+1])
    );
  end

  assign last    = link_w[MAX_PEERS];
  assign finish  = (state_r == ST_SCAN) && last.valid;
  assign is_tick = (op_r == hmt_pkg::OP_TICK);

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    op_nxt        = op_r;
    id_nxt        = id_r;
    port_nxt      = port_r;
    hb_nxt        = hb_r;
    sender_nxt    = sender_r;
    self_hit_nxt  = self_hit_r;
    evict_en_nxt  = evict_en_r;
    due_nxt       = due_r;
    fail_to_nxt   = fail_to_r;
    clean_to_nxt  = clean_to_r;
    period_nxt    = period_r;
    self_id_nxt   = self_id_r;
    self_port_nxt = self_port_r;
    own_hb_nxt    = own_hb_r;
    countdown_nxt = countdown_r;
    member_nxt    = member_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    ev_nxt        = ev_r;
    rem_out_nxt   = rem_out_r;
    cnt_out_nxt   = cnt_out_r;
    add_en        = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        hmt_pkg::CFG_FAIL_TO:  fail_to_nxt   = cfg_wdata;
        hmt_pkg::CFG_CLEAN_TO: clean_to_nxt  = cfg_wdata;
        hmt_pkg::CFG_PERIOD:   period_nxt    = cfg_wdata[hmt_pkg::PER_W-1:0];
        hmt_pkg::CFG_SELF_ID:  self_id_nxt   = cfg_wdata;
        hmt_pkg::CFG_SELF_PRT: self_port_nxt = cfg_wdata;
        hmt_pkg::CFG_IN_GROUP: member_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end

    // launch: latch the beat and apply the own-state part of the item
    if (accept) begin
      state_nxt    = ST_SCAN;
      go_nxt       = 1'b1;
      op_nxt       = in_opcode;
      id_nxt       = in_entry_id;
      port_nxt     = in_entry_port;
      hb_nxt       = in_entry_heartbeat;
      sender_nxt   = in_is_sender;
      self_hit_nxt = (in_entry_id == self_id_r) && (in_entry_port == self_port_r);
      evict_en_nxt = 1'b0;
      due_nxt      = 1'b0;
      case (in_opcode)
        hmt_pkg::OP_TICK: begin
          if (member_r) begin
            evict_en_nxt = 1'b1;
            if (countdown_r == '0) begin
              due_nxt       = 1'b1;
              countdown_nxt = period_r;
              if (own_hb_r != '1) own_hb_nxt = own_hb_r + 1'b1;
            end else begin
              countdown_nxt = countdown_r - 1'b1;
            end
          end
        end
        hmt_pkg::OP_JOIN_REP: member_nxt = 1'b1;
        hmt_pkg::OP_JOIN_REQ: begin
          if (own_hb_r != '1) own_hb_nxt = own_hb_r + 1'b1;
        end
        default: ;
      endcase
    end

    // the beat left the last cell: decide, write a new peer, show the result
    if (finish) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      if (is_tick) begin
        ev_nxt    = hmt_pkg::EV_TICK;
        count_nxt = count_r - removed_w[MAX_PEERS];
        now_nxt   = now_r + 1'b1;
      end else if (self_hit_r) begin
        ev_nxt = hmt_pkg::EV_IGNORED;
      end else if (last.found) begin
        ev_nxt = last.upd ? hmt_pkg::EV_UPDATED : hmt_pkg::EV_IGNORED;
      end else if (last.free_hit) begin
        ev_nxt    = hmt_pkg::EV_ADDED;
        add_en    = 1'b1;
        count_nxt = count_r + 1'b1;
      end else begin
        ev_nxt = hmt_pkg::EV_FULL;
      end
      rem_out_nxt = is_tick ? hmt_pkg::OUT_CNT_W'(removed_w[MAX_PEERS]) : '0;
      cnt_out_nxt = hmt_pkg::OUT_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fail_to_r   <= hmt_pkg::RST_FAIL_TO;
      clean_to_r  <= hmt_pkg::RST_CLEAN_TO;
      period_r    <= hmt_pkg::RST_PERIOD;
      self_id_r   <= hmt_pkg::RST_SELF_ID;
      self_port_r <= hmt_pkg::RST_SELF_PRT;
      own_hb_r    <= '0;
      countdown_r <= hmt_pkg::RST_PERIOD;
      member_r    <= hmt_pkg::RST_IN_GROUP;
      now_r       <= '0;
      count_r     <= '0;
      due_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      fail_to_r   <= fail_to_nxt;
      clean_to_r  <= clean_to_nxt;
      period_r    <= period_nxt;
      self_id_r   <= self_id_nxt;
      self_port_r <= self_port_nxt;
      own_hb_r    <= own_hb_nxt;
      countdown_r <= countdown_nxt;
      member_r    <= member_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      due_r       <= due_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    port_r     <= port_nxt;
    hb_r       <= hb_nxt;
    sender_r   <= sender_nxt;
    self_hit_r <= self_hit_nxt;
    evict_en_r <= evict_en_nxt;
    ev_r       <= ev_nxt;
    rem_out_r  <= rem_out_nxt;
    cnt_out_r  <= cnt_out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = ev_r;
  assign out_removed_count   = rem_out_r;
  assign out_neighbour_count = cnt_out_r;
  assign out_self_heartbeat  = own_hb_r;
  assign out_gossip_due      = due_r;
  assign out_in_group        = member_r;

endmodule

// ===== tb/sv/heartbeat_membership_table_core_tb.sv =====
`timescale 1ns / 100ps

module heartbeat_membership_table_core_tb;
  import hmt_pkg::*;

  localparam int TABLE_SLOTS = MAX_PEERS_DEF;
  localparam int KEYS = 48;
  localparam int PHASE_BEATS = 380;
  localparam int CYCLE_LIMIT = 1000000;
  // indexes past the last register, expected to write nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [EV_W-1:0]      ev;
    logic [OUT_CNT_W-1:0] removed;
    logic [OUT_CNT_W-1:0] peers;
    logic [HB_W-1:0]      self_hb;
    logic                 due;
    logic                 grp;
  } membership_outcome_t;

  class membership_scoreboard;
    logic [TO_W-1:0]   fail_to, clean_to;
    logic [PER_W-1:0]  period, countdown;
    logic [ID_W-1:0]   self_id;
    logic [PORT_W-1:0] self_port;
    logic              member;
    bit                slot_used[TABLE_SLOTS];
    logic [ID_W-1:0]   slot_id[TABLE_SLOTS];
    logic [PORT_W-1:0] slot_port[TABLE_SLOTS];
    logic [HB_W-1:0]   slot_hb[TABLE_SLOTS];
    logic [TIME_W-1:0] slot_stamp[TABLE_SLOTS];
    logic [HB_W-1:0]   own_hb;
    logic [TIME_W-1:0] now;
    int unsigned       peers;
    membership_outcome_t pending[$];
    int errors, checked, n_added, n_updated, n_full, n_evicted, n_rounds;

    function new();
      fail_to = RST_FAIL_TO;
      clean_to = RST_CLEAN_TO;
      period = RST_PERIOD;
      countdown = RST_PERIOD;
      self_id = RST_SELF_ID;
      self_port = RST_SELF_PRT;
      member = RST_IN_GROUP;
      foreach (slot_used[i]) slot_used[i] = 0;
      own_hb = '0;
      now = '0;
      peers = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_FAIL_TO:  fail_to = val;
        CFG_CLEAN_TO: clean_to = val;
        CFG_PERIOD:   period = val[PER_W-1:0];
        CFG_SELF_ID:  self_id = val;
        CFG_SELF_PRT: self_port = val;
        CFG_IN_GROUP: member = val[0];
        default: ;
      endcase
    endfunction

    function void bump_own();
      if (own_hb != '1) own_hb = own_hb + 32'd1;
    endfunction

    function int find_peer(logic [ID_W-1:0] id, logic [PORT_W-1:0] port);
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (slot_used[i] && slot_id[i] == id && slot_port[i] == port) return i;
      return -1;
    endfunction

    // new peers take the lowest free slot
    function logic [EV_W-1:0] admit(logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
                                    logic [HB_W-1:0] hb);
      if (id == self_id && port == self_port) return EV_IGNORED;
      if (find_peer(id, port) >= 0) return EV_IGNORED;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1;
          slot_id[i] = id;
          slot_port[i] = port;
          slot_hb[i] = hb;
          slot_stamp[i] = now;
          peers++;
          return EV_ADDED;
        end
      end
      return EV_FULL;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [PORT_W-1:0] port, logic [HB_W-1:0] hb, logic snd);
      membership_outcome_t want;
      int slot;
      logic [TIME_W-1:0] age;
      want = '0;
      case (op)
        OP_TICK: begin
          if (member) begin
            if (countdown == '0) begin
              bump_own();
              want.due = 1'b1;
              countdown = period;
            end else begin
              countdown = countdown - 1'b1;
            end
            for (int i = 0; i < TABLE_SLOTS; i++) begin
              age = now - slot_stamp[i];
              if (slot_used[i] && age > {16'd0, clean_to}) begin
                slot_used[i] = 0;
                peers--;
                want.removed = want.removed + 1'b1;
              end
            end
          end
          now = now + 32'd1;
          want.ev = EV_TICK;
        end
        OP_GOSSIP: begin
          slot = find_peer(id, port);
          if (id == self_id && port == self_port) begin
            want.ev = EV_IGNORED;
          end else if (slot < 0) begin
            want.ev = admit(id, port, hb);
          end else begin
            age = now - slot_stamp[slot];
            if ((age <= {16'd0, fail_to} || snd) && hb > slot_hb[slot]) begin
              slot_hb[slot] = hb;
              slot_stamp[slot] = now;
              want.ev = EV_UPDATED;
            end else begin
              want.ev = EV_IGNORED;
            end
          end
        end
        OP_JOIN_REP: begin
          member = 1'b1;
          want.ev = admit(id, port, hb);
        end
        default: begin
          bump_own();
          want.ev = admit(id, port, hb);
        end
      endcase
      want.peers = peers[OUT_CNT_W-1:0];
      want.self_hb = own_hb;
      want.grp = member;
      n_added += int'(want.ev == EV_ADDED);
      n_updated += int'(want.ev == EV_UPDATED);
      n_full += int'(want.ev == EV_FULL);
      n_evicted += int'(want.removed);
      n_rounds += int'(want.due);
      pending = {pending, want};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(membership_outcome_t got);
      membership_outcome_t want;
      if (pending.size() == 0) begin
        $error("result beat with no item outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("event_res", 32'(want.ev), 32'(got.ev));
      compare_field("removed_count", 32'(want.removed), 32'(got.removed));
      compare_field("neighbour_count", 32'(want.peers), 32'(got.peers));
      compare_field("self_heartbeat", want.self_hb, got.self_hb);
      compare_field("gossip_due", 32'(want.due), 32'(got.due));
      compare_field("in_group", 32'(want.grp), 32'(got.grp));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [ID_W-1:0]      in_entry_id = '0;
  logic [PORT_W-1:0]    in_entry_port = '0;
  logic [HB_W-1:0]      in_entry_heartbeat = '0;
  logic                 in_is_sender = 1'b0;
  logic                 in_last_in_message = 1'b0;
  logic                 out_valid;
  logic [EV_W-1:0]      out_event_res;
  logic [OUT_CNT_W-1:0] out_removed_count;
  logic [OUT_CNT_W-1:0] out_neighbour_count;
  logic [HB_W-1:0]      out_self_heartbeat;
  logic                 out_gossip_due;
  logic                 out_in_group;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  membership_scoreboard sb;
  membership_outcome_t  seen;
  logic [ID_W-1:0]      pool_id[KEYS];
  logic [PORT_W-1:0]    pool_port[KEYS];
  logic [HB_W-1:0]      hb_floor = '0;
  bit                   calm = 1'b0;
  int                   beats = 0;
  int                   cycles = 0;

  heartbeat_membership_table_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_entry_id         (in_entry_id),
    .in_entry_port       (in_entry_port),
    .in_entry_heartbeat  (in_entry_heartbeat),
    .in_is_sender        (in_is_sender),
    .in_last_in_message  (in_last_in_message),
    .out_valid           (out_valid),
    .out_event_res       (out_event_res),
    .out_removed_count   (out_removed_count),
    .out_neighbour_count (out_neighbour_count),
    .out_self_heartbeat  (out_self_heartbeat),
    .out_gossip_due      (out_gossip_due),
    .out_in_group        (out_in_group),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.ev = out_event_res;
      seen.removed = out_removed_count;
      seen.peers = out_neighbour_count;
      seen.self_hb = out_self_heartbeat;
      seen.due = out_gossip_due;
      seen.grp = out_in_group;
      sb.check_result(seen);
    end
  end

  // start stays high across back-to-back beats; it is lowered only for a gap or a drain
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [PORT_W-1:0] port, input logic [HB_W-1:0] hb,
                           input logic snd, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) calm = !calm;
    gap = calm ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      start <= 1'b0;
      // now and then let the block go idle before the gap runs
      if ($urandom_range(0, 3) == 0) begin
        @(posedge clk);
        while (busy) @(posedge clk);
        gap--;
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_entry_id <= id;
    in_entry_port <= port;
    in_entry_heartbeat <= hb;
    in_is_sender <= snd;
    in_last_in_message <= last;
    do @(posedge clk); while (busy);
    sb.note_item(op, id, port, hb, snd);
    beats++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // keep the own pair and two near misses of it in the pool
  task automatic build_pool();
    pool_id[0] = sb.self_id;
    pool_port[0] = sb.self_port;
    pool_id[1] = sb.self_id;
    pool_port[1] = sb.self_port ^ 16'h0001;
    pool_id[2] = sb.self_id ^ 16'h8000;
    pool_port[2] = sb.self_port;
    for (int i = 3; i < KEYS; i++) begin
      pool_id[i] = ID_W'($urandom);
      pool_port[i] = PORT_W'($urandom);
    end
  endtask

  function automatic logic [HB_W-1:0] pick_hb();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return '0;
      2: return '1;
      default: return hb_floor + $urandom_range(0, 6);
    endcase
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic run_phase(input int goal);
    int done, len, key, kind;
    done = 0;
    build_pool();
    while (done < goal) begin
      kind = int'($urandom_range(0, 19));
      len = 1;
      if (kind < 6) begin
        len = int'($urandom_range(1, 4));
        for (int j = 0; j < len; j++)
          send_item(OP_TICK, ID_W'($urandom), PORT_W'($urandom), $urandom,
                    coin(), coin());
      end else if (kind < 15) begin
        // one gossip message: sender first, last entry marked
        len = int'($urandom_range(1, 5));
        hb_floor = hb_floor + $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          key = int'($urandom_range(0, KEYS - 1));
          send_item(OP_GOSSIP, pool_id[key], pool_port[key], pick_hb(),
                    j == 0 || $urandom_range(0, 7) == 0, j == len - 1);
        end
      end else if (kind < 19) begin
        key = int'($urandom_range(0, KEYS - 1));
        send_item(kind < 17 ? OP_JOIN_REP : OP_JOIN_REQ, pool_id[key], pool_port[key],
                  pick_hb(), coin(), coin());
      end else begin
        send_item(OP_W'($urandom_range(0, 3)), ID_W'($urandom), PORT_W'($urandom),
                  $urandom, coin(), coin());
      end
      done += len;
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats on reset settings, own pair (1, 0)
    send_item(OP_TICK, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0);
    send_item(OP_GOSSIP, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0);
    send_item(OP_GOSSIP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(OP_GOSSIP, 16'd1, 16'd0, 32'd7, 1'b1, 1'b1);
    send_item(OP_GOSSIP, 16'd0, 16'd0, 32'd5, 1'b0, 1'b0);
    send_item(OP_GOSSIP, 16'd0, 16'd0, 32'd5, 1'b0, 1'b1);
    send_item(OP_GOSSIP, 16'd0, 16'd0, 32'd3, 1'b1, 1'b0);
    send_item(OP_JOIN_REP, 16'd1, 16'd0, 32'd9, 1'b0, 1'b0);
    send_item(OP_JOIN_REP, 16'h1234, 16'h5678, 32'hA5A5_5A5A, 1'b0, 1'b0);
    send_item(OP_JOIN_REP, 16'd0, 16'd0, 32'd1, 1'b0, 1'b0);
    send_item(OP_JOIN_REQ, 16'hABCD, 16'd1, 32'd2, 1'b0, 1'b0);
    send_item(OP_JOIN_REQ, 16'd1, 16'd0, 32'd2, 1'b0, 1'b0);
    // age the first peer past the fail timeout, then refresh it as the sender
    repeat (11) send_item(OP_TICK, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0);
    send_item(OP_GOSSIP, 16'd0, 16'd0, 32'd100, 1'b0, 1'b0);
    send_item(OP_GOSSIP, 16'd0, 16'd0, 32'd101, 1'b1, 1'b1);
    drain();

    run_phase(PHASE_BEATS);

    // short timeouts, gossip every tick, start outside the group
    write_reg(CFG_FAIL_TO, 16'd3);
    write_reg(CFG_CLEAN_TO, 16'd6);
    write_reg(CFG_PERIOD, 16'd0);
    write_reg(CFG_SELF_ID, CFG_DAT_W'($urandom));
    write_reg(CFG_SELF_PRT, CFG_DAT_W'($urandom));
    write_reg(CFG_IN_GROUP, 16'd0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    run_phase(PHASE_BEATS);

    // largest settings: nothing ages out, the table fills up
    write_reg(CFG_FAIL_TO, 16'hFFFF);
    write_reg(CFG_CLEAN_TO, 16'hFFFF);
    write_reg(CFG_PERIOD, 16'd255);
    write_reg(CFG_SELF_ID, 16'hFFFF);
    write_reg(CFG_SELF_PRT, 16'hFFFF);
    write_reg(CFG_IN_GROUP, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    run_phase(PHASE_BEATS);

    // smallest nonzero timeouts and period
    write_reg(CFG_FAIL_TO, 16'd1);
    write_reg(CFG_CLEAN_TO, 16'd1);
    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_SELF_ID, 16'd0);
    write_reg(CFG_SELF_PRT, 16'd0);
    write_reg(CFG_IN_GROUP, 16'd1);
    run_phase(PHASE_BEATS);

    write_reg(CFG_FAIL_TO, CFG_DAT_W'($urandom_range(1, 40)));
    write_reg(CFG_CLEAN_TO, CFG_DAT_W'($urandom_range(1, 80)));
    write_reg(CFG_PERIOD, CFG_DAT_W'($urandom_range(0, 6)));
    write_reg(CFG_SELF_ID, CFG_DAT_W'($urandom));
    write_reg(CFG_SELF_PRT, CFG_DAT_W'($urandom));
    write_reg(CFG_IN_GROUP, CFG_DAT_W'($urandom_range(0, 1)));
    run_phase(PHASE_BEATS);

    repeat (3 * TABLE_SLOTS) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("%0d beats in, %0d results checked over five register settings",
             beats, sb.checked);
    $display("peers added %0d, refreshed %0d, dropped on full %0d, evicted %0d, rounds %0d",
             sb.n_added, sb.n_updated, sb.n_full, sb.n_evicted, sb.n_rounds);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hmt_pkg.sv
sv/hmt_cell.sv
sv/heartbeat_membership_table_core.sv
tb/sv/heartbeat_membership_table_core_tb.sv
